// ----- hdl/mmsc_pkg.sv -----
// Package for the matrix mirror symmetry check.
// Shared constants, register indexes and controller/datapath command types.
// No dependencies.
package mmsc_pkg;

  localparam int MAX_ROWS_DEF     = 64;
  localparam int MAX_COLS_DEF     = 64;
  localparam int ELEMENT_BITS_DEF = 32;

  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 7;
  localparam int LOAD_COUNT_BITS = 13;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 2'd1;

  typedef struct packed {
    logic load;          // store the element on the input, bump the count
    logic walk_init;     // reset walk indices and flags
    logic sel_second;    // address the vertical and point partners
    logic check_first;   // compare base against horizontal partner
    logic check_second;  // compare base against vertical and point partners
    logic advance;       // step to the next element
  } cmd_t;

  typedef struct packed {
    logic load_last;     // the element being loaded completes the matrix
    logic walk_last;     // walk is on the final element
  } status_t;

endpackage

// ----- hdl/matrix_mirror_symmetry_check.sv -----
// Matrix mirror symmetry check, top level.
// Depends on mmsc_pkg, mmsc_ctrl, mmsc_datapath (and mmsc_ram below it).
//
// Usage:
//   Configuration: write row_count (index 0) and column_count (index 1) on the
//   cfg channel; a beat moves when cfg_valid and cfg_ready are high (cfg_ready
//   is always high). A value of 0 counts as 1, a value above the maximum as
//   the maximum. Write only while the block is idle.
//   Elements: present element_value with start; a beat is taken when start is
//   high and busy is low. Elements arrive in row-major order, one per cycle
//   while loading, busy stays low.
//   Result: the beat that completes the matrix raises busy. The store is then
//   walked element by element through the states S_RD_A, S_RD_B and S_CHK (two
//   partner pairs read through the two read ports of the element RAM, which
//   has registered read data); then done pulses for one cycle, carrying the
//   three flags. busy drops in the cycle after done.
//   The result cannot be held off; it is valid only while done is high.
//   Reset: sizes return to 1x1, the load count clears, store contents are left
//   as they are (an entry is always written before it is compared).
module matrix_mirror_symmetry_check #(
  parameter int MAX_ROWS     = mmsc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS     = mmsc_pkg::MAX_COLS_DEF,
  parameter int ELEMENT_BITS = mmsc_pkg::ELEMENT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mmsc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mmsc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ELEMENT_BITS-1:0]      element_value,
  output logic                                done,
  output logic                                horizontal_mirror,
  output logic                                vertical_mirror,
  output logic                                point_mirror
);
  import mmsc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  mmsc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mmsc_datapath #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .element_value     (element_value),
    .cmd               (cmd),
    .status            (status),
    .horizontal_mirror (horizontal_mirror),
    .vertical_mirror   (vertical_mirror),
    .point_mirror      (point_mirror)
  );

`ifndef NO_ASSERTIONS
  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result beat outside busy period");

  a_no_result_after_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result beat straight after an element beat");
`endif

endmodule

// ----- hdl/mmsc_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module mmsc_ram #(
  parameter int WIDTH     = 32,
  parameter int DEPTH     = 4096,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr_a,
  input  logic [ADDR_BITS-1:0] raddr_b,
  output logic [WIDTH-1:0]     rdata_a,
  output logic [WIDTH-1:0]     rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- hdl/mmsc_ctrl.sv -----
// Controller for the matrix mirror symmetry check: load, walk and result states.
// Depends on mmsc_pkg.
module mmsc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mmsc_pkg::status_t  status,
  output mmsc_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done
);
  import mmsc_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_RD_A = 5'b00010,
    S_RD_B = 5'b00100,
    S_CHK  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          if (status.load_last) begin
            cmd.walk_init = 1'b1;
            state_next    = S_RD_A;
          end
        end
      end
      S_RD_A: begin
        state_next = S_RD_B;
      end
      S_RD_B: begin
        // first pair of reads lands here while the second pair is issued
        cmd.sel_second  = 1'b1;
        cmd.check_first = 1'b1;
        state_next      = S_CHK;
      end
      S_CHK: begin
        cmd.check_second = 1'b1;
        cmd.advance      = 1'b1;
        state_next       = status.walk_last ? S_DONE : S_RD_A;
      end
      S_DONE: begin
        state_next = S_LOAD;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  assign busy = (state != S_LOAD);
  assign done = (state == S_DONE);

`ifndef NO_ASSERTIONS
  a_done_then_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> (state == S_LOAD))
    else $error("result state not followed by load state");

  a_init_starts_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_init |=> (state == S_RD_A))
    else $error("walk did not start after last element");
`endif

endmodule

// ----- hdl/mmsc_datapath.sv -----
// Datapath for the matrix mirror symmetry check: size registers, load counter,
// element store, walk address generation and the three comparison flags.
// Depends on mmsc_pkg and mmsc_ram.
module mmsc_datapath #(
  parameter int MAX_ROWS     = mmsc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS     = mmsc_pkg::MAX_COLS_DEF,
  parameter int ELEMENT_BITS = mmsc_pkg::ELEMENT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [mmsc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [mmsc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic signed [ELEMENT_BITS-1:0]         element_value,
  input  mmsc_pkg::cmd_t                         cmd,
  output mmsc_pkg::status_t                      status,
  output logic                                   horizontal_mirror,
  output logic                                   vertical_mirror,
  output logic                                   point_mirror
);
  import mmsc_pkg::*;

  localparam int DEPTH     = MAX_ROWS * MAX_COLS;
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TOTAL_W   = $clog2(DEPTH + 1);
  localparam int ROW_BITS  = $clog2(MAX_ROWS + 1);
  localparam int COL_BITS  = $clog2(MAX_COLS + 1);

  // sizes after clamping, and their product
  logic [ROW_BITS-1:0] rows;
  logic [COL_BITS-1:0] cols;
  logic [TOTAL_W-1:0]  total;
  logic [ROW_BITS-1:0] rows_wr;
  logic [COL_BITS-1:0] cols_wr;

  always_comb begin
    if (cfg_data == '0) begin
      rows_wr = ROW_BITS'(1);
      cols_wr = COL_BITS'(1);
    end else begin
      rows_wr = (32'(cfg_data) > MAX_ROWS) ? ROW_BITS'(MAX_ROWS) : ROW_BITS'(cfg_data);
      cols_wr = (32'(cfg_data) > MAX_COLS) ? COL_BITS'(MAX_COLS) : COL_BITS'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows  <= ROW_BITS'(1);
      cols  <= COL_BITS'(1);
      total <= TOTAL_W'(1);
    end else if (cfg_write && cfg_index == REG_ROW_COUNT) begin
      rows  <= rows_wr;
      total <= TOTAL_W'(rows_wr) * TOTAL_W'(cols);
    end else if (cfg_write && cfg_index == REG_COLUMN_COUNT) begin
      cols  <= cols_wr;
      total <= TOTAL_W'(rows) * TOTAL_W'(cols_wr);
    end
  end

  // load counter; size may change mid-load, so compare with >=
  logic [LOAD_COUNT_BITS-1:0] load_count;
  logic [LOAD_COUNT_BITS-1:0] count_inc;

  assign count_inc        = load_count + 1'b1;
  assign status.load_last = (32'(count_inc) >= 32'(total));

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (cmd.load) begin
      load_count <= status.load_last ? '0 : count_inc;
    end
  end

  // walk indices
  logic [TOTAL_W-1:0]  elem_idx;     // row-major index of the base element
  logic [COL_BITS-1:0] col_idx;
  logic [TOTAL_W-1:0]  row_base;     // i * cols
  logic [TOTAL_W-1:0]  mirror_base;  // (rows-1-i) * cols
  logic                row_end;

  assign row_end          = (32'(col_idx) == 32'(cols) - 1);
  assign status.walk_last = (elem_idx == total - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      elem_idx    <= '0;
      col_idx     <= '0;
      row_base    <= '0;
      mirror_base <= total - TOTAL_W'(cols);
    end else if (cmd.advance) begin
      elem_idx <= elem_idx + 1'b1;
      if (row_end) begin
        col_idx     <= '0;
        row_base    <= row_base + TOTAL_W'(cols);
        mirror_base <= mirror_base - TOTAL_W'(cols);
      end else begin
        col_idx <= col_idx + 1'b1;
      end
    end
  end

  logic [TOTAL_W-1:0] addr_a;
  logic [TOTAL_W-1:0] addr_b;

  always_comb begin
    if (cmd.sel_second) begin
      addr_a = row_base + TOTAL_W'(cols) - 1'b1 - TOTAL_W'(col_idx);
      addr_b = total - 1'b1 - elem_idx;
    end else begin
      addr_a = elem_idx;
      addr_b = mirror_base + TOTAL_W'(col_idx);
    end
  end

  logic                    store_we;
  logic [ELEMENT_BITS-1:0] rdata_a;
  logic [ELEMENT_BITS-1:0] rdata_b;

  assign store_we = cmd.load && (32'(load_count) < DEPTH);

  mmsc_ram #(
    .WIDTH     (ELEMENT_BITS),
    .DEPTH     (DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (ADDR_BITS'(load_count)),
    .wdata   (element_value),
    .raddr_a (ADDR_BITS'(addr_a)),
    .raddr_b (ADDR_BITS'(addr_b)),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // every pair is compared from both sides; equality is symmetric so the
  // full sweep gives the same answer as the half sweep
  logic [ELEMENT_BITS-1:0] base_q;

  always_ff @(posedge clk) begin
    if (cmd.check_first) begin
      base_q <= rdata_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      horizontal_mirror <= 1'b1;
      vertical_mirror   <= 1'b1;
      point_mirror      <= 1'b1;
    end else if (cmd.walk_init) begin
      horizontal_mirror <= 1'b1;
      vertical_mirror   <= 1'b1;
      point_mirror      <= 1'b1;
    end else begin
      if (cmd.check_first && rdata_a != rdata_b) begin
        horizontal_mirror <= 1'b0;
      end
      if (cmd.check_second && base_q != rdata_a) begin
        vertical_mirror <= 1'b0;
      end
      if (cmd.check_second && base_q != rdata_b) begin
        point_mirror <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> (elem_idx < total))
    else $error("walk index beyond matrix");

  a_count_restarts: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_init |=> (load_count == '0))
    else $error("load count not cleared at end of matrix");
`endif

endmodule
